/* hdl/sdft_pkg.sv */
// Shared constants, types and twiddle tables for the sliding DFT bin engine.
`timescale 1ns / 1ps
`default_nettype none

package sdft_pkg;

    // Window length and derived widths
    localparam int BINS       = 32;
    localparam int K_W        = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int STEP_W     = $clog2(BINS + 2);

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int BIN_W      = 32;
    localparam int IDX_W      = 5;
    localparam int COUNT_W    = 4;
    localparam int SEL_W      = 3;
    localparam int CHAN_MAX   = 8;

    // Datapath widths
    localparam int Q_SHIFT    = 8;
    localparam int DELTA_W    = SAMPLE_W + 1;
    localparam int ACC_W      = BIN_W + 2;
    localparam int TW_W       = 30;
    localparam int TW_FRAC    = 28;
    localparam int PROD_W     = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COUNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_SEL   = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;
    localparam logic [SEL_W-1:0]   SEL_RESET   = 3'd0;

    // Sweep steps: BINS feed steps, then two more to drain the rotator
    localparam logic [STEP_W-1:0] STEP_FEED_END = STEP_W'(BINS);
    localparam logic [STEP_W-1:0] STEP_LAST     = STEP_W'(BINS + 1);

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Series divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine, n = 1..7
    localparam logic [0:6][7:0] SIN_DEN = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam logic [0:6][7:0] COS_DEN = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic           advance;
        logic           feed;
        logic           take;
        logic [K_W-1:0] k;
    } t_ctrl;

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        index;
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic                    last;
    } t_result;

    typedef logic [BINS-1:0][TW_W-1:0] t_tw_tab;

    // Truncating Taylor series in Q.30: sine when odd is set, else cosine
    function automatic longint taylor_q30(input longint unsigned x, input logic odd);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = odd ? x : Q30_ONE;
        acc  = longint'(term);
        for (int n = 1; n <= 7; n++) begin
            if (odd) begin
                term = ((term * x2) >> 30) / SIN_DEN[n - 1];
            end else begin
                term = ((term * x2) >> 30) / COS_DEN[n - 1];
            end
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return acc;
    endfunction

    // Q.28 twiddle e^(+j*2*pi*k/BINS): cosine table, or sine table when want_sin
    function automatic t_tw_tab tw_table(input logic want_sin);
        t_tw_tab         tab;
        longint unsigned four_k;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint          cc;
        longint          ss;
        longint          cv;
        longint          sv;
        tab = '0;
        for (int k = 0; k < BINS; k++) begin
            four_k = 64'(4 * k);
            q  = four_k / BINS;
            r  = four_k - q * BINS;
            x  = (HALF_PI_Q30 * r) / BINS;
            cc = (taylor_q30(x, 1'b0) + 2) >>> 2;
            ss = (taylor_q30(x, 1'b1) + 2) >>> 2;
            case (q[1:0])
                2'd0: begin
                    cv = cc;
                    sv = ss;
                end
                2'd1: begin
                    cv = -ss;
                    sv = cc;
                end
                2'd2: begin
                    cv = -cc;
                    sv = -ss;
                end
                default: begin
                    cv = ss;
                    sv = -cc;
                end
            endcase
            tab[k] = want_sin ? TW_W'(sv) : TW_W'(cv);
        end
        return tab;
    endfunction

    localparam t_tw_tab TW_COS = tw_table(1'b0);
    localparam t_tw_tab TW_SIN = tw_table(1'b1);

endpackage

`default_nettype wire

/* hdl/sliding_dft_bins.sv */
// Top level of the sliding DFT: bin ring of cells, shared rotator, sequencer, output register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | in        | i_in_valid/o_in_stall | i_sample
//  out     | out       | o_out_valid/i_out_stall | o_bin_index, o_bin_real, o_bin_imag,
//          |           |                       | o_last_bin
//  cfg     | in        | i_cfg_we              | i_cfg_index, i_cfg_data
//
// A sample of another channel is taken and gives no result.
// For a kept sample the ring of BINS cells turns BINS + 2 times past the one shared rotator,
// which has two register stages; results leave one per cycle unless the output stalls.
// A stall on a held result freezes the ring and the rotator; the last result may wait while
// the next sample is taken. Synchronous reset clears bins, history and channel position,
// and sets channel count 1, channel select 0.
`timescale 1ns / 1ps
`default_nettype none

module sliding_dft_bins
    import sdft_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [IDX_W-1:0]                o_bin_index,
    output logic signed [BIN_W-1:0]         o_bin_real,
    output logic signed [BIN_W-1:0]         o_bin_imag,
    output logic                            o_last_bin
);

    t_ctrl   ctl;
    t_result res;

    logic signed [BIN_W-1:0]    w_re   [BINS];
    logic signed [BIN_W-1:0]    w_im   [BINS];
    logic signed [SAMPLE_W-1:0] w_hist [BINS];

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_index;
    logic signed [BIN_W-1:0] r_out_re;
    logic signed [BIN_W-1:0] r_out_im;
    logic                    r_out_last;

    sdft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_out_hold  (r_out_valid && i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_ctl       (ctl)
    );

    // Cell 0 is the head: oldest sample and the bin entering the rotator.
    // Results re-enter at the far end, so the ring is back in order after a sweep.
    for (genvar i = 0; i < BINS; i++) begin : g_cell
        if (i == BINS - 1) begin : g_tail
            sdft_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_bin_shift  (ctl.advance),
                .i_hist_shift (ctl.take),
                .i_bin_re     (res.re),
                .i_bin_im     (res.im),
                .i_hist       (i_sample),
                .o_bin_re     (w_re[i]),
                .o_bin_im     (w_im[i]),
                .o_hist       (w_hist[i])
            );
        end else begin : g_body
            sdft_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_bin_shift  (ctl.advance),
                .i_hist_shift (ctl.take),
                .i_bin_re     (w_re[i+1]),
                .i_bin_im     (w_im[i+1]),
                .i_hist       (w_hist[i+1]),
                .o_bin_re     (w_re[i]),
                .o_bin_im     (w_im[i]),
                .o_hist       (w_hist[i])
            );
        end
    end

    sdft_rotator u_rotator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_bin_re (w_re[0]),
        .i_bin_im (w_im[0]),
        .i_new    (i_sample),
        .i_old    (w_hist[0]),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.advance && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.advance && res.valid) begin
            r_out_index <= res.index;
            r_out_re    <= res.re;
            r_out_im    <= res.im;
            r_out_last  <= res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_out_index;
    assign o_bin_real  = r_out_re;
    assign o_bin_imag  = r_out_im;
    assign o_last_bin  = r_out_last;

endmodule

`default_nettype wire

/* hdl/sdft_cell.sv */
// One cell of the bin ring and of the sample history line.
`timescale 1ns / 1ps
`default_nettype none

module sdft_cell
    import sdft_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_bin_shift,
    input  wire logic                       i_hist_shift,
    input  wire logic signed [BIN_W-1:0]    i_bin_re,
    input  wire logic signed [BIN_W-1:0]    i_bin_im,
    input  wire logic signed [SAMPLE_W-1:0] i_hist,
    output logic signed [BIN_W-1:0]         o_bin_re,
    output logic signed [BIN_W-1:0]         o_bin_im,
    output logic signed [SAMPLE_W-1:0]      o_hist
);

    logic signed [BIN_W-1:0]    r_re;
    logic signed [BIN_W-1:0]    r_im;
    logic signed [SAMPLE_W-1:0] r_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re <= '0;
            r_im <= '0;
        end else if (i_bin_shift) begin
            r_re <= i_bin_re;
            r_im <= i_bin_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_hist_shift) begin
            r_hist <= i_hist;
        end
    end

    assign o_bin_re = r_re;
    assign o_bin_im = r_im;
    assign o_hist   = r_hist;

endmodule

`default_nettype wire

/* hdl/sdft_rotator.sv */
// Shared bin update: add the window delta, rotate by the twiddle, round and saturate.
`timescale 1ns / 1ps
`default_nettype none

module sdft_rotator
    import sdft_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_ctrl                      i_ctl,
    input  wire logic signed [BIN_W-1:0]    i_bin_re,
    input  wire logic signed [BIN_W-1:0]    i_bin_im,
    input  wire logic signed [SAMPLE_W-1:0] i_new,
    input  wire logic signed [SAMPLE_W-1:0] i_old,
    output t_result                         o_res
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (TW_FRAC - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI     = (PROD_W'(1) <<< (BIN_W - 1)) - 1;
    localparam logic signed [PROD_W-1:0] SAT_LO     = -(PROD_W'(1) <<< (BIN_W - 1));

    logic signed [DELTA_W-1:0] r_delta;

    logic                      r_s1_valid;
    logic [K_W-1:0]            r_s1_k;
    logic signed [ACC_W-1:0]   r_s1_ar;
    logic signed [BIN_W-1:0]   r_s1_ai;
    logic signed [TW_W-1:0]    r_s1_c;
    logic signed [TW_W-1:0]    r_s1_s;

    logic                      r_s2_valid;
    logic [K_W-1:0]            r_s2_k;
    logic signed [PROD_W-1:0]  r_s2_rc;
    logic signed [PROD_W-1:0]  r_s2_is;
    logic signed [PROD_W-1:0]  r_s2_rs;
    logic signed [PROD_W-1:0]  r_s2_ic;

    logic signed [ACC_W-1:0]   n_ar;

    function automatic logic signed [BIN_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = (v + ROUND_HALF) >>> TW_FRAC;
        if (t > SAT_HI) begin
            return SAT_HI[BIN_W-1:0];
        end else if (t < SAT_LO) begin
            return SAT_LO[BIN_W-1:0];
        end
        return t[BIN_W-1:0];
    endfunction

    // Hold new minus oldest sample for the whole sweep
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_delta <= DELTA_W'(i_new) - DELTA_W'(i_old);
        end
    end

    assign n_ar = ACC_W'(i_bin_re) + (ACC_W'(r_delta) <<< Q_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_s1_valid <= i_ctl.feed;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_s1_k  <= i_ctl.k;
            r_s1_ar <= n_ar;
            r_s1_ai <= i_bin_im;
            r_s1_c  <= $signed(TW_COS[i_ctl.k]);
            r_s1_s  <= $signed(TW_SIN[i_ctl.k]);

            r_s2_k  <= r_s1_k;
            r_s2_rc <= PROD_W'(r_s1_ar) * PROD_W'(r_s1_c);
            r_s2_is <= PROD_W'(r_s1_ai) * PROD_W'(r_s1_s);
            r_s2_rs <= PROD_W'(r_s1_ar) * PROD_W'(r_s1_s);
            r_s2_ic <= PROD_W'(r_s1_ai) * PROD_W'(r_s1_c);
        end
    end

    always_comb begin
        o_res.valid = r_s2_valid;
        o_res.index = IDX_W'(r_s2_k);
        o_res.re    = round_sat(r_s2_rc - r_s2_is);
        o_res.im    = round_sat(r_s2_rs + r_s2_ic);
        o_res.last  = (r_s2_k == K_W'(BINS - 1));
    end

endmodule

`default_nettype wire

/* hdl/sdft_ctrl.sv */
// Configuration registers, channel tracking and the per-sample sweep sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sdft_ctrl
    import sdft_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_out_hold,
    output logic                       o_in_stall,
    output t_ctrl                      o_ctl
);

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [SEL_W-1:0]     r_sel;
    logic [SEL_W-1:0]     r_pos;
    logic [SEL_W-1:0]     n_pos;
    logic [STEP_W-1:0]    r_step;

    logic [COUNT_W-1:0]   count_eff;
    logic                 accept;
    logic                 take;
    logic                 advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            r_sel   <= SEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHAN_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                CFG_CHAN_SEL:   r_sel   <= i_cfg_data[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Channel bookkeeping for the item on the input
    always_comb begin
        count_eff = (r_count > COUNT_W'(CHAN_MAX)) ? COUNT_W'(CHAN_MAX) : r_count;
        accept    = i_in_valid && (r_state == ST_IDLE);
        take      = accept && (count_eff != '0) && (COUNT_W'(r_sel) < count_eff)
                    && (r_pos == r_sel);
        if (count_eff == '0) begin
            n_pos = '0;
        end else if (COUNT_W'(r_pos) + COUNT_W'(1) >= count_eff) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + SEL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (advance && (r_step == STEP_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        advance    = (r_state == ST_SWEEP) && !i_out_hold;
        o_in_stall = (r_state != ST_IDLE);
        o_ctl.advance = advance;
        o_ctl.feed    = (r_state == ST_SWEEP) && (r_step < STEP_FEED_END);
        o_ctl.take    = take;
        o_ctl.k       = r_step[K_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_step <= '0;
            end else if (advance) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sim/dft_bin_checker.sv */
`timescale 1ns / 1ps
// Bin checker: watches the sample, result and register ports, predicts every bin and compares.
module dft_bin_checker
    import sdft_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [IDX_W-1:0]           i_bin_index,
    input  logic signed [BIN_W-1:0]    i_bin_real,
    input  logic signed [BIN_W-1:0]    i_bin_imag,
    input  logic                       i_last_bin,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint unsigned ROT_ONE     = 64'd1 << 30;
    localparam longint unsigned ROT_QUARTER = 64'd1686629713;
    localparam longint          SAT_HI      = 64'sh7FFFFFFF;
    localparam longint          SAT_LO      = -64'sh80000000;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic                    last;
    } bin_t;

    logic signed [BIN_W-1:0]    bin_re [BINS];
    logic signed [BIN_W-1:0]    bin_im [BINS];
    logic signed [SAMPLE_W-1:0] window [BINS];
    longint                     rot_cos [BINS];
    longint                     rot_sin [BINS];
    int                         oldest_slot;
    int                         chan_pos;
    logic [COUNT_W-1:0]         chan_count;
    logic [SEL_W-1:0]           chan_sel;
    bin_t                       due_bins [$];
    int                         err_count = 0;

    // Truncating series over one quadrant, Q.30: sine when odd, else cosine
    function automatic longint quadrant_series(input longint unsigned x, input bit odd);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint          acc;
        x2   = (x * x) >> 30;
        term = odd ? x : ROT_ONE;
        acc  = longint'(term);
        for (int n = 1; n <= 7; n++) begin
            den  = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = ((term * x2) >> 30) / den;
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        return (acc < 0) ? 64'sd0 : acc;
    endfunction

    // Round a Q.36 product sum to Q.8 toward the nearest, ties up, then clamp
    function automatic logic signed [BIN_W-1:0] to_q8_sat(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 27)) >>> 28;
        if (r > SAT_HI) begin
            return BIN_W'(SAT_HI);
        end else if (r < SAT_LO) begin
            return BIN_W'(SAT_LO);
        end
        return BIN_W'(r);
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Slide the window by one kept sample and queue all bins it produces
    task automatic slide_bins(input logic signed [SAMPLE_W-1:0] fresh_sample);
        longint fresh;
        longint oldest;
        longint ar;
        longint ai;
        bin_t   b;
        oldest = longint'(window[oldest_slot]) * 256;
        window[oldest_slot] = fresh_sample;
        fresh = longint'(fresh_sample) * 256;
        oldest_slot = (oldest_slot + 1) % BINS;
        for (int k = 0; k < BINS; k++) begin
            ar = longint'(bin_re[k]) - oldest + fresh;
            ai = longint'(bin_im[k]);
            bin_re[k] = to_q8_sat(ar * rot_cos[k] - ai * rot_sin[k]);
            bin_im[k] = to_q8_sat(ar * rot_sin[k] + ai * rot_cos[k]);
            b.index = IDX_W'(k);
            b.re    = bin_re[k];
            b.im    = bin_im[k];
            b.last  = (k == BINS - 1);
            due_bins.insert(due_bins.size(), b);
        end
    endtask

    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        int span;
        bit keep;
        span = (int'(chan_count) > CHAN_MAX) ? CHAN_MAX : int'(chan_count);
        if (span == 0) begin
            chan_pos = 0;
            return;
        end
        keep = (int'(chan_sel) < span) && (chan_pos == int'(chan_sel));
        // wrap also when a shrunken count left the position past its end
        chan_pos = (chan_pos + 1 >= span) ? 0 : ((chan_pos + 1) & 7);
        if (keep) begin
            slide_bins(s);
        end
    endtask

    initial begin : build_twiddles
        longint unsigned quarter;
        longint unsigned rem;
        longint unsigned x;
        longint          cc;
        longint          ss;
        for (int k = 0; k < BINS; k++) begin
            quarter = (4 * k) / BINS;
            rem     = 4 * k - quarter * BINS;
            x       = (ROT_QUARTER * rem) / BINS;
            cc      = (quadrant_series(x, 1'b0) + 2) >>> 2;
            ss      = (quadrant_series(x, 1'b1) + 2) >>> 2;
            case (quarter % 4)
                0: begin
                    rot_cos[k] = cc;
                    rot_sin[k] = ss;
                end
                1: begin
                    rot_cos[k] = -ss;
                    rot_sin[k] = cc;
                end
                2: begin
                    rot_cos[k] = -cc;
                    rot_sin[k] = -ss;
                end
                default: begin
                    rot_cos[k] = ss;
                    rot_sin[k] = -cc;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : watch
        bin_t want;
        if (!i_rst_n) begin
            for (int k = 0; k < BINS; k++) begin
                bin_re[k] = '0;
                bin_im[k] = '0;
                window[k] = '0;
            end
            oldest_slot = 0;
            chan_pos    = 0;
            chan_count  = COUNT_RESET;
            chan_sel    = SEL_RESET;
            due_bins.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CHAN_COUNT) begin
                    chan_count = i_cfg_data[COUNT_W-1:0];
                end else if (i_cfg_index == CFG_CHAN_SEL) begin
                    chan_sel = i_cfg_data[SEL_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_bins.size() == 0) begin
                    err_count++;
                    $display("%0t: bin expected none actual index %0d re %0d im %0d",
                             $time, i_bin_index, i_bin_real, i_bin_imag);
                end else begin
                    want = due_bins.pop_front();
                    check_field("bin_index", want.index, i_bin_index);
                    check_field("bin_real", want.re, i_bin_real);
                    check_field("bin_imag", want.im, i_bin_imag);
                    check_field("last_bin", want.last, i_last_bin);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_sample(i_sample);
            end
        end
        o_errors  <= err_count;
        o_pending <= due_bins.size();
    end

endmodule

/* sim/sliding_dft_bins_test.sv */
`timescale 1ns / 1ps
// Top of the sliding DFT bins test: clock, reset, sample and register stimulus, verdict.
module sliding_dft_bins_test;
    import sdft_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       i_out_stall = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [IDX_W-1:0]           o_bin_index;
    logic signed [BIN_W-1:0]    o_bin_real;
    logic signed [BIN_W-1:0]    o_bin_imag;
    logic                       o_last_bin;

    int   bin_errors;
    int   bins_pending;
    int   cycles    = 0;
    int   hold_left = 0;
    logic calm      = 1'b0;
    logic hold_go   = 1'b0;
    logic hold_go_q = 1'b0;

    sliding_dft_bins uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_bin_index (o_bin_index),
        .o_bin_real  (o_bin_real),
        .o_bin_imag  (o_bin_imag),
        .o_last_bin  (o_last_bin)
    );

    dft_bin_checker bin_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_bin_index (o_bin_index),
        .i_bin_real  (o_bin_real),
        .i_bin_imag  (o_bin_imag),
        .i_last_bin  (o_last_bin),
        .o_errors    (bin_errors),
        .o_pending   (bins_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off started by a rising hold_go
    always @(posedge i_clk) begin
        hold_go_q <= hold_go;
        if (hold_go && !hold_go_q) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Offer one item and hold it until accepted; valid stays high for the next one
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_pair(input logic [CFG_IDX_W-1:0] idx_a,
                              input logic [CFG_DATA_W-1:0] data_a,
                              input logic [CFG_IDX_W-1:0] idx_b,
                              input logic [CFG_DATA_W-1:0] data_b);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx_a;
        i_cfg_data  <= data_a;
        @(posedge i_clk);
        i_cfg_index <= idx_b;
        i_cfg_data  <= data_b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Drop valid, wait for every queued bin, then let a stray sweep finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bins_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic signed [SAMPLE_W-1:0] corner [7];
        logic signed [SAMPLE_W-1:0] value;
        int span;
        int pick;
        int sel;
        int n_items;
        corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                   16'sh5555, 16'shAAAA};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // spare indexes must leave count 1, select 0 in place
        write_pair(CFG_SPARE_A, 4'hF, CFG_SPARE_B, 4'h5);
        for (int i = 0; i < 7; i++) begin
            push_sample(corner[i]);
        end
        settle();
        // select data masks to 2: third channel of three is kept
        write_pair(CFG_CHAN_COUNT, 4'd3, CFG_CHAN_SEL, 4'hA);
        for (int i = 0; i < 3; i++) begin
            push_sample(corner[i]);
        end
        settle();
        // select beyond count: nothing kept
        write_pair(CFG_CHAN_COUNT, 4'd2, CFG_CHAN_SEL, 4'd5);
        push_sample(corner[0]);
        push_sample(corner[1]);
        settle();
        write_pair(CFG_CHAN_COUNT, 4'd0, CFG_CHAN_SEL, 4'd0);
        push_sample(corner[0]);
        push_sample(corner[1]);
        settle();
        // count above eight acts as eight; stop with the position at three
        write_pair(CFG_CHAN_COUNT, 4'd15, CFG_CHAN_SEL, 4'd7);
        for (int i = 0; i < 11; i++) begin
            push_sample(corner[i % 7]);
        end
        settle();
        // position now past the count: the first item wraps it
        write_pair(CFG_CHAN_COUNT, 4'd2, CFG_CHAN_SEL, 4'd1);
        push_sample(corner[1]);
        push_sample(corner[0]);
        settle();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin
                    span = 1;
                    sel = 0;
                    n_items = 60;
                end
                1: begin
                    span = 2;
                    sel = 1;
                    n_items = 40;
                end
                2: begin
                    span = 8;
                    sel = 7;
                    n_items = 40;
                end
                3: begin
                    span = 0;
                    sel = 0;
                    n_items = 8;
                end
                4: begin
                    span = 12;
                    sel = 3;
                    n_items = 24;
                end
                default: begin
                    span = $urandom_range(1, 8);
                    sel = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, span - 1);
                    n_items = 20;
                end
            endcase
            write_pair(CFG_CHAN_COUNT, CFG_DATA_W'(span), CFG_CHAN_SEL, CFG_DATA_W'(sel));
            if (ph == 0) begin
                calm <= 1'b1;
            end
            for (int i = 0; i < n_items; i++) begin
                if (ph == 0 && i == 30) begin
                    calm <= 1'b0;
                end
                // hold the receiver off while items keep coming
                if (ph == 0 && i == 40) begin
                    hold_go <= 1'b1;
                end
                if (ph == 0 && i == 42) begin
                    hold_go <= 1'b0;
                end
                pick = $urandom_range(0, 9);
                case (pick)
                    0: value = 16'sh7FFF;
                    1: value = 16'sh8000;
                    2: value = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
                    default: value = SAMPLE_W'($urandom());
                endcase
                push_sample(value);
            end
            settle();
        end

        if (bin_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
